// ----- sv/rgb_pixel_distance_grey_defines.svh -----
// Assertion macros for the checker file of the pixel distance block.
`ifndef RGB_PIXEL_DISTANCE_GREY_DEFINES_SVH
`define RGB_PIXEL_DISTANCE_GREY_DEFINES_SVH

// Property checked on every rising clock edge once reset is released.
`define RPDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, including during reset.
`define RPDG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/rpdg_pkg.sv -----
// Types and constants shared by the pixel distance grey pipeline.
`default_nettype none

package rpdg_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned SumW   = 18;
  localparam int unsigned QuoW   = 16;
  localparam int unsigned RootW  = 8;
  localparam int unsigned ProdW  = 36;

  // floor(x / 3) equals (x * Recip3) >> Recip3Shift for every x below 2**18.
  localparam logic [SumW-1:0] Recip3      = 18'd174763;
  localparam int unsigned     Recip3Shift = 19;

  localparam logic [ChanW-1:0] OpaqueAlpha = 8'hff;

  // Red sits in the lowest byte, alpha in the highest.
  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgba_t;

  typedef struct packed {
    logic masked;
    logic last;
  } side_t;

endpackage

`default_nettype wire

// ----- sv/rgb_pixel_distance_grey.sv -----
// Top level of the RGB pixel distance to grey converter.
// Takes one pair of RGBA pixels per transfer and delivers the grey level
// floor(sqrt(floor((dr^2 + dg^2 + db^2) / 3))) as an opaque grey ARGB word; a
// pair with either alpha at zero gives opaque black with the masked flag set.
// One pixel pair is accepted every clock unless a stall holds off the input:
// four stages form the difference, squares, sum and reciprocal multiply by
// three, four stages resolve two root bits each, and one output register
// holds the result. Stalls from the output side back up only through full
// stages, so bubbles are squeezed out before the input is held off.
`default_nettype none

module rgb_pixel_distance_grey (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // first_red, first_green, first_blue, first_alpha,
  // second_red, second_green, second_blue, second_alpha
  input  wire logic [63:0] s_axis_tdata,
  // end_of_image
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // grey_level [7:0], out_pixel [39:8]
  output logic [39:0]      m_axis_tdata,
  // masked
  output logic             m_axis_tuser,
  // end_of_image_out
  output logic             m_axis_tlast
);

  rpdg_pkg::rgba_t first_pix;
  rpdg_pkg::rgba_t second_pix;

  logic                        sd_valid;
  logic                        sd_ready;
  logic [rpdg_pkg::QuoW-1:0]   sd_quo;
  rpdg_pkg::side_t             sd_side;

  logic                        sq_valid;
  logic                        sq_ready;
  logic [rpdg_pkg::RootW-1:0]  sq_root;
  rpdg_pkg::side_t             sq_side;

  logic                        out_valid_q;
  logic                        out_valid_d;
  logic [rpdg_pkg::RootW-1:0]  grey_q;
  rpdg_pkg::side_t             side_q;

  assign first_pix  = rpdg_pkg::rgba_t'(s_axis_tdata[31:0]);
  assign second_pix = rpdg_pkg::rgba_t'(s_axis_tdata[63:32]);

  rpdg_sqdist u_sqdist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .first_i     (first_pix),
    .second_i    (second_pix),
    .last_i      (s_axis_tlast),
    .out_valid_o (sd_valid),
    .out_ready_i (sd_ready),
    .quo_o       (sd_quo),
    .side_o      (sd_side)
  );

  rpdg_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sd_valid),
    .in_ready_o  (sd_ready),
    .rad_i       (sd_quo),
    .side_i      (sd_side),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  assign sq_ready    = !out_valid_q || m_axis_tready;
  assign out_valid_d = sq_ready ? sq_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The root of a 16-bit radicand never exceeds 255, so no clamp logic is needed.
  always_ff @(posedge clk_i) begin
    if (sq_ready && sq_valid) begin
      grey_q <= sq_root;
      side_q <= sq_side;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {rpdg_pkg::OpaqueAlpha, grey_q, grey_q, grey_q, grey_q};
  assign m_axis_tuser  = side_q.masked;
  assign m_axis_tlast  = side_q.last;

endmodule

`default_nettype wire

// ----- sv/rpdg_sqdist.sv -----
// Pipelined squared color distance divided by three.
`default_nettype none

module rpdg_sqdist (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire rpdg_pkg::rgba_t             first_i,
  input  wire rpdg_pkg::rgba_t             second_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rpdg_pkg::QuoW-1:0]        quo_o,
  output rpdg_pkg::side_t                  side_o
);

  localparam int unsigned NumStages = 4;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] valid_in;
  logic [NumStages:0]   stage_rdy;
  logic [NumStages-1:0] load;

  logic [rpdg_pkg::ChanW-1:0] dr_q, dg_q, db_q;
  logic [2*rpdg_pkg::ChanW-1:0] sqr_q, sqg_q, sqb_q;
  logic [rpdg_pkg::SumW-1:0]  sum_q;
  logic [rpdg_pkg::ProdW-1:0] prod_q;
  rpdg_pkg::side_t side_q [NumStages];
  rpdg_pkg::side_t side_in;
  logic            masked;

  function automatic logic [rpdg_pkg::ChanW-1:0] abs_diff(
    input logic [rpdg_pkg::ChanW-1:0] a,
    input logic [rpdg_pkg::ChanW-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // A stage can take new data when it is empty or its content moves on.
  always_comb begin
    stage_rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign valid_in = {valid_q[NumStages-2:0], in_valid_i};
  assign load     = stage_rdy[NumStages-1:0] & valid_in;

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      valid_d[k] = stage_rdy[k] ? valid_in[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign masked         = (first_i.alpha == '0) || (second_i.alpha == '0);
  assign side_in.masked = masked;
  assign side_in.last   = last_i;

  // A masked pair enters with zero differences, so its grey level comes out as zero.
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      dr_q      <= masked ? '0 : abs_diff(first_i.red, second_i.red);
      dg_q      <= masked ? '0 : abs_diff(first_i.green, second_i.green);
      db_q      <= masked ? '0 : abs_diff(first_i.blue, second_i.blue);
      side_q[0] <= side_in;
    end
    if (load[1]) begin
      sqr_q     <= {8'd0, dr_q} * {8'd0, dr_q};
      sqg_q     <= {8'd0, dg_q} * {8'd0, dg_q};
      sqb_q     <= {8'd0, db_q} * {8'd0, db_q};
      side_q[1] <= side_q[0];
    end
    if (load[2]) begin
      sum_q     <= rpdg_pkg::SumW'(sqr_q) + rpdg_pkg::SumW'(sqg_q)
                   + rpdg_pkg::SumW'(sqb_q);
      side_q[2] <= side_q[1];
    end
    if (load[3]) begin
      prod_q    <= rpdg_pkg::ProdW'(sum_q) * rpdg_pkg::ProdW'(rpdg_pkg::Recip3);
      side_q[3] <= side_q[2];
    end
  end

  assign in_ready_o  = stage_rdy[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign quo_o       = prod_q[rpdg_pkg::Recip3Shift +: rpdg_pkg::QuoW];
  assign side_o      = side_q[NumStages-1];

endmodule

`default_nettype wire

// ----- sv/rpdg_isqrt.sv -----
// Pipelined integer square root, two result bits per stage.
`default_nettype none

module rpdg_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [rpdg_pkg::QuoW-1:0]   rad_i,
  input  wire rpdg_pkg::side_t             side_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rpdg_pkg::RootW-1:0]       root_o,
  output rpdg_pkg::side_t                  side_o
);

  localparam int unsigned NumStages = rpdg_pkg::RootW / 2;
  localparam int unsigned RemW      = rpdg_pkg::RootW + 1;
  localparam int unsigned AccW      = RemW + 2;

  typedef struct packed {
    logic [rpdg_pkg::QuoW-1:0]  rad;
    logic [RemW-1:0]            rem;
    logic [rpdg_pkg::RootW-1:0] root;
    rpdg_pkg::side_t            side;
  } sq_stage_t;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] valid_in;
  logic [NumStages:0]   stage_rdy;
  logic [NumStages-1:0] load;

  sq_stage_t stage_q  [NumStages];
  sq_stage_t stage_in [NumStages];

  // Two steps of the digit-by-digit method; each takes the next two radicand bits.
  function automatic sq_stage_t sqrt_pair(input sq_stage_t s);
    sq_stage_t       r;
    logic [AccW-1:0] acc;
    logic [AccW-1:0] trial;
    r = s;
    for (int i = 0; i < 2; i++) begin
      acc   = {r.rem, r.rad[rpdg_pkg::QuoW-1 -: 2]};
      trial = {1'b0, r.root, 2'b01};
      if (acc >= trial) begin
        r.rem  = RemW'(acc - trial);
        r.root = {r.root[rpdg_pkg::RootW-2:0], 1'b1};
      end else begin
        r.rem  = acc[RemW-1:0];
        r.root = {r.root[rpdg_pkg::RootW-2:0], 1'b0};
      end
      r.rad = {r.rad[rpdg_pkg::QuoW-3:0], 2'b00};
    end
    return r;
  endfunction

  always_comb begin
    stage_rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign valid_in = {valid_q[NumStages-2:0], in_valid_i};
  assign load     = stage_rdy[NumStages-1:0] & valid_in;

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      valid_d[k] = stage_rdy[k] ? valid_in[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    stage_in[0].rad  = rad_i;
    stage_in[0].rem  = '0;
    stage_in[0].root = '0;
    stage_in[0].side = side_i;
    for (int k = 1; k < NumStages; k++) begin
      stage_in[k] = stage_q[k-1];
    end
  end

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (load[g]) begin
        stage_q[g] <= sqrt_pair(stage_in[g]);
      end
    end
  end

  assign in_ready_o  = stage_rdy[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign root_o      = stage_q[NumStages-1].root;
  assign side_o      = stage_q[NumStages-1].side;

endmodule

`default_nettype wire

// ----- sv/rpdg_checker.sv -----
// Port-level checks of the pixel distance grey block and their binding.
`default_nettype none
`include "rgb_pixel_distance_grey_defines.svh"

module rpdg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A masked pair must come out with a grey level of zero (black).
  `RPDG_ASSERT(a_masked_black, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0, "masked result is not black")

  // The pixel word is opaque and carries the grey level in all three colors.
  `RPDG_ASSERT(a_pixel_grey, m_axis_tvalid |-> m_axis_tdata[39:32] == 8'hff && m_axis_tdata[31:24] == m_axis_tdata[7:0] && m_axis_tdata[23:16] == m_axis_tdata[7:0] && m_axis_tdata[15:8] == m_axis_tdata[7:0], "output pixel is not opaque grey")

  // A stalled result holds until its transfer.
  `RPDG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // Nothing is offered while reset is held.
  `RPDG_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "result offered during reset")

endmodule

bind rgb_pixel_distance_grey rpdg_checker u_rpdg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/rgb_pixel_distance_grey_monitor.sv -----
// Checker that predicts and compares the grey level results of the pixel distance block.
`default_nettype none

module rgb_pixel_distance_grey_monitor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [63:0] s_tdata_i,
  input  wire logic        s_tlast_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [39:0] m_tdata_i,
  input  wire logic        m_tuser_i,
  input  wire logic        m_tlast_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      waiting_o
);

  typedef struct packed {
    logic [7:0]  grey;
    logic        masked;
    logic [31:0] pixel;
    logic        last;
  } grey_result_t;

  grey_result_t grey_queue[$];
  int unsigned  mismatches = 0;
  int unsigned  waiting    = 0;

  assign mismatch_count_o = mismatches;
  assign waiting_o        = waiting;

  function automatic logic [17:0] chan_dist_sq(logic [7:0] x, logic [7:0] y);
    logic [17:0] d;
    d = (x > y) ? 18'(x - y) : 18'(y - x);
    return d * d;
  endfunction

  function automatic grey_result_t distance_grey(rpdg_pkg::rgba_t first,
                                                 rpdg_pkg::rgba_t second, logic last);
    grey_result_t res;
    logic [17:0]  sum;
    logic [17:0]  quo;
    logic [17:0]  root;
    logic [17:0]  trial;
    res.masked = (first.alpha == 8'd0) || (second.alpha == 8'd0);
    root = '0;
    if (!res.masked) begin
      sum = chan_dist_sq(first.red, second.red) + chan_dist_sq(first.green, second.green)
          + chan_dist_sq(first.blue, second.blue);
      quo = sum / 18'd3;
      // Build the root one bit at a time from the top; nine bits leave room for the clamp.
      for (int b = 8; b >= 0; b--) begin
        trial = root | (18'd1 << b);
        if (trial * trial <= 36'(quo)) begin
          root = trial;
        end
      end
      if (root > 18'd255) begin
        root = 18'd255;
      end
    end
    res.grey  = root[7:0];
    res.pixel = 32'hff000000 + {24'd0, res.grey} * 32'h00010101;
    res.last  = last;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    grey_result_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) begin
        grey_queue.push_back(distance_grey(rpdg_pkg::rgba_t'(s_tdata_i[31:0]),
                                           rpdg_pkg::rgba_t'(s_tdata_i[63:32]),
                                           s_tlast_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (grey_queue.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata_i);
          mismatches++;
        end else begin
          want = grey_queue.pop_front();
          check_field("grey_level", 32'(want.grey), 32'(m_tdata_i[7:0]));
          check_field("masked", 32'(want.masked), 32'(m_tuser_i));
          check_field("out_pixel", want.pixel, m_tdata_i[39:8]);
          check_field("end_of_image_out", 32'(want.last), 32'(m_tlast_i));
        end
      end
      waiting <= grey_queue.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/rgb_pixel_distance_grey_test.sv -----
// Stimulus and verdict for the pixel distance grey block.
`default_nettype none

module rgb_pixel_distance_grey_test;

  localparam int unsigned IdleLimit   = 500;
  localparam int unsigned RandomPairs = 850;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned mismatch_count;
  int unsigned waiting;
  int unsigned quiet_cycles = 0;
  bit          gaps_on  = 1'b1;
  bit          stalls_on = 1'b1;

  rgb_pixel_distance_grey uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  rgb_pixel_distance_grey_monitor monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tlast_i        (s_axis_tlast),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .m_tlast_i        (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .waiting_o        (waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run ends if neither side completes a transfer for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("[rgb_pixel_distance_grey] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts while enabled.
  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic rpdg_pkg::rgba_t px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] a);
    return '{alpha: a, blue: b, green: g, red: r};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pair(rpdg_pkg::rgba_t first, rpdg_pkg::rgba_t second, logic last);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second, first};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
    @(negedge clk_i);
  endtask

  task automatic send_random_pair();
    rpdg_pkg::rgba_t a;
    rpdg_pkg::rgba_t b;
    a = rpdg_pkg::rgba_t'($urandom);
    b = rpdg_pkg::rgba_t'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        // Nearly equal colors give small distances.
        b.red   = a.red ^ 8'($urandom_range(0, 15));
        b.green = a.green ^ 8'($urandom_range(0, 15));
        b.blue  = a.blue ^ 8'($urandom_range(0, 15));
      end
      1: begin
        b.red   = ~a.red;
        b.green = ~a.green;
        b.blue  = ~a.blue;
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) a.alpha = 8'd0;
    if ($urandom_range(0, 9) == 0) b.alpha = 8'd0;
    send_pair(a, b, $urandom_range(0, 15) == 0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_pair(px(0, 0, 0, 255), px(0, 0, 0, 255), 1'b0);
    send_pair(px(255, 255, 255, 255), px(0, 0, 0, 255), 1'b0);
    send_pair(px(0, 0, 0, 255), px(255, 255, 255, 255), 1'b1);
    send_pair(px(255, 0, 0, 1), px(0, 0, 0, 1), 1'b0);
    send_pair(px(0, 255, 0, 128), px(0, 0, 0, 255), 1'b0);
    send_pair(px(0, 0, 255, 255), px(0, 0, 0, 128), 1'b0);
    // Masked pairs: either alpha at zero forces black, the marker still passes.
    send_pair(px(255, 255, 255, 0), px(0, 0, 0, 255), 1'b1);
    send_pair(px(255, 255, 255, 255), px(0, 0, 0, 0), 1'b0);
    send_pair(px(255, 255, 255, 0), px(255, 255, 255, 0), 1'b1);
    // Small sums check the floors of the quotient and of the root.
    send_pair(px(1, 1, 0, 255), px(0, 0, 0, 255), 1'b0);
    send_pair(px(1, 1, 1, 255), px(0, 0, 0, 255), 1'b0);
    send_pair(px(2, 2, 2, 255), px(0, 0, 0, 255), 1'b0);
    send_pair(px(3, 0, 0, 255), px(0, 0, 0, 255), 1'b0);
    send_pair(px(0, 0, 0, 255), px(3, 3, 3, 255), 1'b0);
    send_pair(px(170, 85, 170, 255), px(85, 170, 85, 255), 1'b0);
    send_pair(px(200, 100, 50, 128), px(100, 200, 150, 127), 1'b1);
    send_pair(px(85, 85, 85, 255), px(170, 170, 170, 255), 1'b0);
    drain_results();

    for (int i = 0; i < RandomPairs; i++) begin
      if (i == RandomPairs / 2) begin
        drain_results();
      end
      if (i == RandomPairs - 150) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      send_random_pair();
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (waiting != 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && waiting == 0) begin
      $display("[rgb_pixel_distance_grey] OK");
    end else begin
      $display("[rgb_pixel_distance_grey] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
